// ===== hw/rtl/edd_pkg.sv =====
// shared types and constants for the error diffusion dither line buffer
// no dependencies; imported by every module of the block

package edd_pkg;

  localparam int MaxWidth     = 512;
  localparam int CfgWidthBits = 10;
  localparam int GrayBits     = 8;
  localparam int ErrBits      = 8;
  localparam int CfgAddrBits  = 3;
  localparam int CfgDataBits  = 32;

  localparam logic [CfgWidthBits-1:0] LineWidthReset = 10'd512;

  // register index, taken from paddr[2]
  localparam logic RegIdxLineWidth = 1'b0;

  typedef struct packed {
    logic [GrayBits-1:0] gray_pixel;
    logic                frame_start;
  } edd_in_t;

  typedef struct packed {
    logic [7:0] packed_bits;
    logic       line_end;
  } edd_out_t;

  // per-pixel control handed from the front stage to the error stage
  typedef struct packed {
    logic       first_line;
    logic       frame_start;
    logic       last;
    logic       col_nz;
    logic [2:0] bit_pos;
  } edd_ctl_t;

endpackage

// ===== hw/rtl/edd_line_mem.sv =====
// line error store: one write port, one registered read port
// uses edd_pkg for the entry width

module edd_line_mem #(
  parameter int Depth = edd_pkg::MaxWidth,
  parameter int Aw    = $clog2(edd_pkg::MaxWidth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [Aw-1:0]              waddr_i,
  input  logic [edd_pkg::ErrBits-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [Aw-1:0]              raddr_i,
  output logic [edd_pkg::ErrBits-1:0] rdata_o
);
  import edd_pkg::*;

  logic [ErrBits-1:0] mem [Depth];
  logic [ErrBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/edd_front.sv =====
// front stage: column tracking, line width clamp, store read issue
// and the stage-one item register; uses edd_pkg

module edd_front #(
  parameter int MaxW = edd_pkg::MaxWidth,
  parameter int Aw   = $clog2(edd_pkg::MaxWidth)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic                              fire_i,
  input  edd_pkg::edd_in_t                  in_data_i,
  input  logic [edd_pkg::CfgWidthBits-1:0]  line_width_i,
  output logic [Aw-1:0]                     rd_addr_o,
  output logic                              s1_valid_o,
  output logic [edd_pkg::GrayBits-1:0]      s1_gray_o,
  output logic [Aw-1:0]                     s1_col_o,
  output edd_pkg::edd_ctl_t                 s1_ctl_o
);
  import edd_pkg::*;

  localparam int Ww = (Aw + 1 > CfgWidthBits) ? Aw + 1 : CfgWidthBits;

  logic [Aw-1:0]       col_q, col_d, col_cur;
  logic                first_q, first_d, first_cur;
  logic [Ww-1:0]       width_raw, width_used;
  logic                last;
  logic                s1_valid_q, s1_valid_d;
  logic [GrayBits-1:0] gray_q;
  logic [Aw-1:0]       s1_col_q;
  edd_ctl_t            ctl_q, ctl_d;

  // width rounded down to a multiple of 8, kept within 8..MaxW
  always_comb begin
    width_raw = Ww'({line_width_i[CfgWidthBits-1:3], 3'b000});
    if (width_raw < Ww'(8)) begin
      width_used = Ww'(8);
    end else if (width_raw > Ww'(MaxW)) begin
      width_used = Ww'(MaxW);
    end else begin
      width_used = width_raw;
    end
  end

  always_comb begin
    col_cur   = in_data_i.frame_start ? '0 : col_q;
    first_cur = in_data_i.frame_start | first_q;
    last      = (Ww'(col_cur) + Ww'(1)) >= width_used;

    col_d   = col_q;
    first_d = first_q;
    if (accept_i) begin
      if (last) begin
        col_d   = '0;
        first_d = 1'b0;
      end else begin
        col_d   = col_cur + Aw'(1);
        first_d = first_cur;
      end
    end

    ctl_d.first_line  = first_cur;
    ctl_d.frame_start = in_data_i.frame_start;
    ctl_d.last        = last;
    ctl_d.col_nz      = (col_cur != '0);
    ctl_d.bit_pos     = col_cur[2:0];

    s1_valid_d = accept_i | (s1_valid_q & ~fire_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      first_q    <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      first_q    <= first_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      gray_q   <= in_data_i.gray_pixel;
      s1_col_q <= col_cur;
      ctl_q    <= ctl_d;
    end
  end

  assign rd_addr_o  = col_cur;
  assign s1_valid_o = s1_valid_q;
  assign s1_gray_o  = gray_q;
  assign s1_col_o   = s1_col_q;
  assign s1_ctl_o   = ctl_q;

endmodule

// ===== hw/rtl/edd_err_unit.sv =====
// error stage: threshold, error split, carries, bit packing and
// store write-back with one deferred write for the line end; uses edd_pkg

module edd_err_unit #(
  parameter int Aw = $clog2(edd_pkg::MaxWidth)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s1_valid_i,
  input  logic                         fire_i,
  input  logic [edd_pkg::GrayBits-1:0] gray_i,
  input  logic [Aw-1:0]                col_i,
  input  edd_pkg::edd_ctl_t            ctl_i,
  input  logic [edd_pkg::ErrBits-1:0]  rdata_i,
  output logic                         has_res_o,
  output edd_pkg::edd_out_t            res_o,
  output logic                         we_o,
  output logic [Aw-1:0]                waddr_o,
  output logic [edd_pkg::ErrBits-1:0]  wdata_o
);
  import edd_pkg::*;

  logic signed [6:0]         rc_q, rc_cur, rc_new;
  logic signed [3:0]         brc_q, brc_cur, e;
  logic signed [ErrBits-1:0] pend_q, pend_cur, pend_new, below, e8, left_data;
  logic [7:0]                gather_q, gather_cur, gather_new;
  logic signed [9:0]         sum;
  logic [7:0]                old;
  logic signed [8:0]         err;
  logic                      white;
  logic signed [6:0]         e7;
  logic                      s1_we;
  logic                      dw_valid_q, dw_valid_d;
  logic [Aw-1:0]             dw_addr_q;
  logic [ErrBits-1:0]        dw_data_q;

  always_comb begin
    rc_cur     = ctl_i.frame_start ? '0 : rc_q;
    brc_cur    = ctl_i.frame_start ? '0 : brc_q;
    pend_cur   = ctl_i.frame_start ? '0 : pend_q;
    gather_cur = ctl_i.frame_start ? '0 : gather_q;
    below      = ctl_i.first_line ? '0 : $signed(rdata_i);

    sum   = $signed({2'b00, gray_i}) + 10'(below) + 10'(rc_cur);
    white = (sum >= 10'sd128);
    if (sum < 10'sd0) begin
      old = 8'd0;
    end else if (sum > 10'sd255) begin
      old = 8'd255;
    end else begin
      old = sum[7:0];
    end
    err = $signed({1'b0, old}) - (white ? 9'sd255 : 9'sd0);
    // floor of err / 16, always within -8..7
    e   = $signed(err[7:4]);

    e7        = 7'(e);
    e8        = 8'(e);
    rc_new    = (e7 <<< 3) - e7;
    pend_new  = 8'(brc_cur) + (e8 <<< 2) + e8;
    left_data = pend_cur + (e8 <<< 1) + e8;

    gather_new = gather_cur | (white ? (8'h80 >> ctl_i.bit_pos) : 8'h00);

    has_res_o         = s1_valid_i & (ctl_i.last | (ctl_i.bit_pos == 3'd7));
    res_o.packed_bits = gather_new;
    res_o.line_end    = ctl_i.last;
  end

  // below-left share goes to col-1; the line end share for the last
  // column is held until the stage writes nothing, at the latest when column 0 fires
  always_comb begin
    s1_we      = fire_i & ctl_i.col_nz;
    dw_valid_d = dw_valid_q;
    if (fire_i && ctl_i.last) begin
      dw_valid_d = 1'b1;
    end else if (!s1_we) begin
      dw_valid_d = 1'b0;
    end
    we_o    = s1_we | dw_valid_q;
    waddr_o = s1_we ? (col_i - Aw'(1)) : dw_addr_q;
    wdata_o = s1_we ? left_data : dw_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q       <= '0;
      brc_q      <= '0;
      pend_q     <= '0;
      gather_q   <= '0;
      dw_valid_q <= 1'b0;
    end else begin
      dw_valid_q <= dw_valid_d;
      if (fire_i) begin
        if (ctl_i.last) begin
          rc_q     <= '0;
          brc_q    <= '0;
          pend_q   <= '0;
          gather_q <= '0;
        end else begin
          rc_q     <= rc_new;
          brc_q    <= e;
          pend_q   <= pend_new;
          gather_q <= (ctl_i.bit_pos == 3'd7) ? 8'h00 : gather_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && ctl_i.last) begin
      dw_addr_q <= col_i;
      dw_data_q <= pend_new;
    end
  end

endmodule

// ===== hw/rtl/error_diffusion_dither_line_buffer_core.sv =====
// top level of the error diffusion dither with one-line error store
// depends on edd_pkg, edd_front, edd_err_unit and edd_line_mem
//
// usage:
// - input channel (in_valid_i, in_stall_o, in_data_i) takes one gray pixel
//   per transaction in raster order; frame_start marks column 0 of a frame
// - output channel (out_valid_o, out_stall_i, out_data_o) gives one byte of
//   dithered bits every eight pixels, leftmost pixel in bit 7, line_end set
//   on the last byte of a line
// - APB port sets line_width (byte address 0), pixels per line, rounded
//   down to a multiple of 8 and kept within 8..MAX_WIDTH; write it only
//   while the block is idle
// - throughput is one pixel per cycle unless a stalled output holds it;
//   the limit is the error stage that closes the left-carry loop pixel to pixel
// - a pixel reads its store entry as it is accepted into stage one, is
//   thresholded in the error stage and its byte is registered into the
//   output register that drives out_data_o
// - the store has one write port: the line-end write for the last column
//   is held back, at the latest to the slot where column 0 writes nothing
// - when the receiver stalls with a byte waiting, pixels that complete no
//   byte still pass; a pixel that would complete one holds the error stage
//   and in_stall_o rises until the output register frees up
// - reset clears carries, column count and valid flags, sets first-line
//   mode (store reads as zero) and line_width to 512; no store clearing

module error_diffusion_dither_line_buffer_core #(
  parameter int MAX_WIDTH = edd_pkg::MaxWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  edd_pkg::edd_in_t                    in_data_i,
  // packed byte output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output edd_pkg::edd_out_t                   out_data_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [edd_pkg::CfgAddrBits-1:0]     paddr,
  input  logic [edd_pkg::CfgDataBits-1:0]     pwdata,
  output logic [edd_pkg::CfgDataBits-1:0]     prdata,
  output logic                                pready
);
  import edd_pkg::*;

  localparam int Aw = $clog2(MAX_WIDTH);

  logic [CfgWidthBits-1:0] line_width_q, line_width_d;
  logic                    cfg_wr;

  logic                    accept, fire, blocked;
  logic [Aw-1:0]           rd_addr;
  logic                    s1_valid;
  logic [GrayBits-1:0]     s1_gray;
  logic [Aw-1:0]           s1_col;
  edd_ctl_t                s1_ctl;
  logic [ErrBits-1:0]      rdata;

  logic                    has_res;
  edd_out_t                res;
  logic                    mem_we;
  logic [Aw-1:0]           mem_waddr;
  logic [ErrBits-1:0]      mem_wdata;

  logic                    out_valid_q, out_valid_d;
  edd_out_t                out_data_q;
  logic                    out_load;

  // config register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == RegIdxLineWidth);

  always_comb begin
    line_width_d = cfg_wr ? pwdata[CfgWidthBits-1:0] : line_width_q;
    prdata       = (paddr[2] == RegIdxLineWidth) ? CfgDataBits'(line_width_q) : '0;
  end

  // handshake: stage one holds only when it has a byte and the
  // output register is full and stalled
  always_comb begin
    blocked     = s1_valid & has_res & out_valid_q & out_stall_i;
    in_stall_o  = blocked;
    accept      = in_valid_i & ~blocked;
    fire        = s1_valid & ~blocked;
    out_load    = fire & has_res;
    out_valid_d = out_load | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthReset;
      out_valid_q  <= 1'b0;
    end else begin
      line_width_q <= line_width_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  edd_front #(
    .MaxW (MAX_WIDTH),
    .Aw   (Aw)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .fire_i       (fire),
    .in_data_i    (in_data_i),
    .line_width_i (line_width_q),
    .rd_addr_o    (rd_addr),
    .s1_valid_o   (s1_valid),
    .s1_gray_o    (s1_gray),
    .s1_col_o     (s1_col),
    .s1_ctl_o     (s1_ctl)
  );

  // store read is issued with the accept, so its data stays put while
  // stage one is held
  edd_line_mem #(
    .Depth (MAX_WIDTH),
    .Aw    (Aw)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  edd_err_unit #(
    .Aw (Aw)
  ) u_err (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .fire_i     (fire),
    .gray_i     (s1_gray),
    .col_i      (s1_col),
    .ctl_i      (s1_ctl),
    .rdata_i    (rdata),
    .has_res_o  (has_res),
    .res_o      (res),
    .we_o       (mem_we),
    .waddr_o    (mem_waddr),
    .wdata_o    (mem_wdata)
  );

endmodule

// ===== hw/rtl/edd_checker.sv =====
// port-level checks for the dither core, bound to the top level
// uses edd_pkg types; attached by the bind statement at the end

module edd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input edd_pkg::edd_out_t               out_data_o,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [edd_pkg::CfgAddrBits-1:0] paddr,
  input logic [edd_pkg::CfgDataBits-1:0] pwdata,
  input logic [edd_pkg::CfgDataBits-1:0] prdata,
  input logic                            pready
);
  import edd_pkg::*;

  // a waiting byte stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // input back-pressure only comes from a full, stalled output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // line_width reads back what was written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr == 3'd0
    |=> paddr != 3'd0 || prdata == 32'($past(pwdata[CfgWidthBits-1:0])))
    else $error("line_width readback mismatch");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind error_diffusion_dither_line_buffer_core edd_checker u_edd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);
